// File: sv/tlls_pkg.sv
// tlls_pkg: shared types, register file map and the solver's microprogram
// for the three-line least-squares point block. No dependencies.
`timescale 1ns / 1ps

package tlls_pkg;

  // default coordinate width (signed, Q1.30 at 32 bits)
  localparam int COORD_WIDTH_DEF = 32;

  // scratch register file map
  localparam int RF_DEPTH = 64;
  localparam int RF_AW    = 6;
  localparam int A_P      = 0;   // six points, three axes each
  localparam int A_D      = 18;  // line directions
  localparam int A_E      = 27;  // right-hand side combinations
  localparam int A_S      = 36;  // per-axis sum of line starts
  localparam int A_M00    = 39;
  localparam int A_M11    = 40;
  localparam int A_M22    = 41;
  localparam int A_M10    = 42;
  localparam int A_M20    = 43;
  localparam int A_M21    = 44;
  localparam int A_RH     = 45;
  localparam int A_C      = 48;  // c00 c01 c02 c11 c12 c22
  localparam int A_DET    = 54;
  localparam int A_N      = 55;
  localparam int A_DETP   = 58;  // determinant made positive
  localparam int A_NP     = 59;  // numerators with the same sign flip
  localparam int A_X      = 62;

  // length of an immediate multiplier in serial steps
  localparam int IMM_LEN  = 4;
  localparam int PROG_LEN = 143;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_FETCH,
    S_LOAD,
    S_MUL,
    S_WB,
    S_DIV,
    S_OUT
  } state_t;

  // where the serial multiplier operand comes from
  typedef enum logic [1:0] {
    BSRC_REG,
    BSRC_IMM,
    BSRC_SGN
  } bsrc_t;

  // serial length class of the multiplier operand
  typedef enum logic [1:0] {
    LEN_IMM,
    LEN_D,
    LEN_S,
    LEN_M
  } len_t;

  // action taken at write-back
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DET,
    ACT_NEG,
    ACT_D6,
    ACT_DIV
  } act_t;

  typedef struct packed {
    logic [RF_AW-1:0] a_adr;
    bsrc_t            bsrc;
    logic [RF_AW-1:0] b_adr;
    logic signed [3:0] imm;
    logic             neg;
    logic             clr;
    len_t             len;
    logic             wr;
    logic [RF_AW-1:0] dst;
    act_t             act;
  } op_t;

  typedef op_t [PROG_LEN-1:0] prog_t;

  function automatic op_t mk(input int a_adr, input bsrc_t bsrc, input int b_adr,
                             input int imm, input bit neg, input bit clr,
                             input len_t len, input bit wr, input int dst,
                             input act_t act);
    op_t o;
    o.a_adr = RF_AW'(a_adr);
    o.bsrc  = bsrc;
    o.b_adr = RF_AW'(b_adr);
    o.imm   = 4'(imm);
    o.neg   = neg;
    o.clr   = clr;
    o.len   = len;
    o.wr    = wr;
    o.dst   = RF_AW'(dst);
    o.act   = act;
    return o;
  endfunction

  // address of cofactor (i,j), symmetric
  function automatic int cadr(input int i, input int j);
    int lo;
    int hi;
    lo = (i < j) ? i : j;
    hi = (i < j) ? j : i;
    if (lo == 0) return A_C + hi;
    if (lo == 1) return A_C + 2 + hi;
    return A_C + 5;
  endfunction

  // solver microprogram, built at elaboration
  function automatic prog_t build_prog();
    prog_t p;
    int k;
    int i;
    int j;
    int a;
    int r;
    int t;
    int q1;
    int q2;
    int dst;
    int di;
    int dj;
    int rep;
    int x1;
    int y1;
    int x2;
    int y2;
    bit ng;
    p = '0;
    k = 0;
    // line directions d_i = p(2i+1) - p(2i)
    for (i = 0; i < 3; i++) begin
      for (a = 0; a < 3; a++) begin
        p[k] = mk(A_P + 3*(2*i+1) + a, BSRC_IMM, 0, 1, 0, 1, LEN_IMM, 0, 0, ACT_NONE);
        k++;
        p[k] = mk(A_P + 3*(2*i) + a, BSRC_IMM, 0, -1, 0, 0, LEN_IMM, 1, A_D + 3*i + a,
                  ACT_NONE);
        k++;
      end
    end
    // e_i = two other line starts minus twice this one
    for (i = 0; i < 3; i++) begin
      q1 = (i == 0) ? 2 : 0;
      q2 = (i == 2) ? 2 : 4;
      for (a = 0; a < 3; a++) begin
        p[k] = mk(A_P + 3*q1 + a, BSRC_IMM, 0, 1, 0, 1, LEN_IMM, 0, 0, ACT_NONE);
        k++;
        p[k] = mk(A_P + 3*q2 + a, BSRC_IMM, 0, 1, 0, 0, LEN_IMM, 0, 0, ACT_NONE);
        k++;
        p[k] = mk(A_P + 3*(2*i) + a, BSRC_IMM, 0, -2, 0, 0, LEN_IMM, 1, A_E + 3*i + a,
                  ACT_NONE);
        k++;
      end
    end
    // sum of line starts per axis
    for (a = 0; a < 3; a++) begin
      for (i = 0; i < 3; i++) begin
        p[k] = mk(A_P + 3*(2*i) + a, BSRC_IMM, 0, 1, 0, (i == 0), LEN_IMM, (i == 2),
                  A_S + a, ACT_NONE);
        k++;
      end
    end
    // normal matrix from direction dot products
    for (r = 0; r < 6; r++) begin
      case (r)
        0: begin dst = A_M00; di = 0; dj = 0; ng = 0; rep = 2; end
        1: begin dst = A_M11; di = 1; dj = 1; ng = 0; rep = 2; end
        2: begin dst = A_M22; di = 2; dj = 2; ng = 0; rep = 2; end
        3: begin dst = A_M10; di = 0; dj = 1; ng = 1; rep = 1; end
        4: begin dst = A_M20; di = 0; dj = 2; ng = 1; rep = 1; end
        default: begin dst = A_M21; di = 1; dj = 2; ng = 1; rep = 1; end
      endcase
      for (t = 0; t < rep; t++) begin
        for (a = 0; a < 3; a++) begin
          p[k] = mk(A_D + 3*dj + a, BSRC_REG, A_D + 3*di + a, 0, ng,
                    (t == 0 && a == 0), LEN_D, (t == rep - 1 && a == 2), dst, ACT_NONE);
          k++;
        end
      end
    end
    // right-hand side rh_i = d_i . e_i
    for (i = 0; i < 3; i++) begin
      for (a = 0; a < 3; a++) begin
        p[k] = mk(A_E + 3*i + a, BSRC_REG, A_D + 3*i + a, 0, 0, (a == 0), LEN_D,
                  (a == 2), A_RH + i, ACT_NONE);
        k++;
      end
    end
    // cofactors c = x1*y1 - x2*y2
    for (r = 0; r < 6; r++) begin
      case (r)
        0: begin x1 = A_M11; y1 = A_M22; x2 = A_M21; y2 = A_M21; end
        1: begin x1 = A_M20; y1 = A_M21; x2 = A_M10; y2 = A_M22; end
        2: begin x1 = A_M10; y1 = A_M21; x2 = A_M20; y2 = A_M11; end
        3: begin x1 = A_M00; y1 = A_M22; x2 = A_M20; y2 = A_M20; end
        4: begin x1 = A_M10; y1 = A_M20; x2 = A_M00; y2 = A_M21; end
        default: begin x1 = A_M00; y1 = A_M11; x2 = A_M10; y2 = A_M10; end
      endcase
      p[k] = mk(y1, BSRC_REG, x1, 0, 0, 1, LEN_M, 0, 0, ACT_NONE);
      k++;
      p[k] = mk(y2, BSRC_REG, x2, 0, 1, 0, LEN_M, 1, A_C + r, ACT_NONE);
      k++;
    end
    // determinant
    p[k] = mk(A_C + 0, BSRC_REG, A_M00, 0, 0, 1, LEN_M, 0, 0, ACT_NONE);
    k++;
    p[k] = mk(A_C + 1, BSRC_REG, A_M10, 0, 0, 0, LEN_M, 0, 0, ACT_NONE);
    k++;
    p[k] = mk(A_C + 2, BSRC_REG, A_M20, 0, 0, 0, LEN_M, 1, A_DET, ACT_DET);
    k++;
    // numerators
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        p[k] = mk(cadr(i, j), BSRC_REG, A_RH + j, 0, 0, (j == 0), LEN_M, (j == 2),
                  A_N + i, ACT_NONE);
        k++;
      end
    end
    // flip signs so that det is positive, check n >= 0
    for (i = 0; i < 3; i++) begin
      p[k] = mk(A_N + i, BSRC_SGN, 0, 0, 0, 1, LEN_IMM, 1, A_NP + i, ACT_NEG);
      k++;
    end
    p[k] = mk(A_DET, BSRC_SGN, 0, 0, 0, 1, LEN_IMM, 1, A_DETP, ACT_NONE);
    k++;
    // check n <= det
    for (i = 0; i < 3; i++) begin
      p[k] = mk(A_DETP, BSRC_IMM, 0, 1, 0, 1, LEN_IMM, 0, 0, ACT_NONE);
      k++;
      p[k] = mk(A_NP + i, BSRC_IMM, 0, -1, 0, 0, LEN_IMM, 0, 0, ACT_NEG);
      k++;
    end
    // divisor 6*det
    p[k] = mk(A_DETP, BSRC_IMM, 0, 6, 0, 1, LEN_IMM, 0, 0, ACT_D6);
    k++;
    // per axis: x = s*det + sum d_i*n_i, then y = 2x + 3det and divide
    for (a = 0; a < 3; a++) begin
      p[k] = mk(A_DETP, BSRC_REG, A_S + a, 0, 0, 1, LEN_S, 0, 0, ACT_NONE);
      k++;
      for (i = 0; i < 3; i++) begin
        p[k] = mk(A_NP + i, BSRC_REG, A_D + 3*i + a, 0, 0, 0, LEN_D, (i == 2), A_X,
                  ACT_NONE);
        k++;
      end
      p[k] = mk(A_X, BSRC_IMM, 0, 2, 0, 1, LEN_IMM, 0, 0, ACT_NONE);
      k++;
      p[k] = mk(A_DETP, BSRC_IMM, 0, 3, 0, 0, LEN_IMM, 0, 0, ACT_DIV);
      k++;
    end
    return p;
  endfunction

endpackage

// File: sv/tlls_if.sv
// tlls_if: valid/ready channel interfaces for points in and results out.
// Depends on nothing.
`timescale 1ns / 1ps

interface tlls_pt_if;
  logic        valid;
  logic        ready;
  logic [31:0] coord_u;
  logic [31:0] coord_v;
  logic [31:0] coord_w;

  modport source (output valid, output coord_u, output coord_v, output coord_w,
                  input ready);
  modport sink (input valid, input coord_u, input coord_v, input coord_w,
                output ready);
endinterface

interface tlls_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_u;
  logic [31:0] result_v;
  logic [31:0] result_w;
  logic [1:0]  status;

  modport source (output valid, output result_u, output result_v, output result_w,
                  output status, input ready);
  modport sink (input valid, input result_u, input result_v, input result_w,
                input status, output ready);
endinterface

// File: sv/tlls_regfile.sv
// tlls_regfile: one write port, two registered read ports scratch memory.
// Depends on nothing.
`timescale 1ns / 1ps

module tlls_regfile #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 244
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra0,
  input  logic [AW-1:0] ra1,
  output logic [DW-1:0] rd0,
  output logic [DW-1:0] rd1
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

// File: sv/three_line_least_squares_point.sv
// three_line_least_squares_point: top level, sequencer and serial datapath.
// Depends on tlls_pkg, tlls_if and tlls_regfile.
`timescale 1ns / 1ps

// Takes six points A..F, one word each, spanning lines AB, CD and EF, and
// returns one word per set: the average of the three line points that solve
// the least-squares meeting problem, with status ok, singular or out_of_range.
// Each of the first five points is accepted and then written into the scratch
// memory, one write per axis. The sixth then runs a 143-step microprogram on
// one shared radix-2 serial multiply-accumulate unit with a single wide adder;
// the multiplier operand is 4 bits for immediates, W+2 or W+3 for differences
// and sums and 2W+4 for matrix terms (W = COORD_WIDTH), and a restoring
// division per axis follows. Singular or out-of-range sets stop early.
// While busy the input is not ready; a finished result waits in the output
// register while the next set is taken in.
module three_line_least_squares_point #(
  parameter int COORD_WIDTH = tlls_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tlls_pt_if.sink    in_pt,
  tlls_res_if.source out_res
);

  localparam int XW   = 7*COORD_WIDTH + 20;
  localparam int BW   = 2*COORD_WIDTH + 4;
  localparam int CW   = $clog2(BW + 1);
  localparam int DVW  = $clog2(COORD_WIDTH);
  localparam int RW   = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int PC_W = $clog2(tlls_pkg::PROG_LEN);
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(tlls_pkg::PROG_LEN - 1);
  localparam tlls_pkg::prog_t PROG = tlls_pkg::build_prog();

  tlls_pkg::state_t  state_r, state_nxt;
  tlls_pkg::status_t status_r;
  tlls_pkg::op_t     op;

  logic [2:0]            pts_r;
  logic [1:0]            st_k_r;
  logic [tlls_pkg::RF_AW-1:0] st_adr_r;
  logic [XW-1:0]         cu_r, cv_r, cw_r;
  logic [PC_W-1:0]       pc_r;
  logic [CW-1:0]         cnt_r;
  logic [XW-1:0]         acc_r, areg_r;
  logic [BW-1:0]         breg_r;
  logic                  det_neg_r;
  logic [XW-1:0]         d6_r, rem_r, dvs_r;
  logic [DVW-1:0]        dcnt_r;
  logic [COORD_WIDTH-1:0] q_r;
  logic [1:0]            axis_r;
  logic [31:0]           res_r [3];
  logic                  out_valid_r;
  logic [31:0]           out_u_r, out_v_r, out_w_r;
  logic [1:0]            out_status_r;

  logic                  in_acc, out_free, acc_zero, acc_neg, div_ge;
  logic                  rf_we;
  logic [tlls_pkg::RF_AW-1:0] rf_wa;
  logic [XW-1:0]         rf_wd, rd_a, rd_b;
  logic [CW-1:0]         op_len;
  logic [COORD_WIDTH-1:0] q_fin;
  logic signed [COORD_WIDTH:0] q_res;
  logic [XW-1:0]         d6_sh;

  // sign-extend the low COORD_WIDTH bits of a 32-bit port word
  function automatic logic [XW-1:0] coord_ext(input logic [31:0] raw);
    logic [RW-1:0]                 wide;
    logic signed [COORD_WIDTH-1:0] c;
    wide = RW'(raw);
    c    = wide[COORD_WIDTH-1:0];
    return XW'(c);
  endfunction

  assign op       = PROG[pc_r];
  assign in_acc   = in_pt.valid && in_pt.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign acc_zero = (acc_r == '0);
  assign acc_neg  = acc_r[XW-1];
  assign div_ge   = $signed(rem_r) >= $signed(dvs_r);
  assign q_fin    = {q_r[COORD_WIDTH-2:0], div_ge};
  assign q_res    = $signed({1'b0, q_fin}) - $signed((COORD_WIDTH+1)'(1) <<
                    (COORD_WIDTH-1));
  assign d6_sh    = d6_r << (COORD_WIDTH-1);

  // serial length of the current op
  always_comb begin
    unique case (op.len)
      tlls_pkg::LEN_IMM: op_len = CW'(tlls_pkg::IMM_LEN);
      tlls_pkg::LEN_D:   op_len = CW'(COORD_WIDTH + 2);
      tlls_pkg::LEN_S:   op_len = CW'(COORD_WIDTH + 3);
      default:           op_len = CW'(BW);
    endcase
  end

  // scratch memory write port
  always_comb begin
    rf_we = 1'b0;
    rf_wa = st_adr_r;
    rf_wd = acc_r;
    if (state_r == tlls_pkg::S_STORE) begin
      rf_we = 1'b1;
      case (st_k_r)
        2'd0:    rf_wd = cu_r;
        2'd1:    rf_wd = cv_r;
        default: rf_wd = cw_r;
      endcase
    end else if (state_r == tlls_pkg::S_WB) begin
      rf_we = op.wr;
      rf_wa = op.dst;
    end
  end

  tlls_regfile #(
    .DEPTH (tlls_pkg::RF_DEPTH),
    .AW    (tlls_pkg::RF_AW),
    .DW    (XW)
  ) u_rf (
    .clk (clk),
    .we  (rf_we),
    .wa  (rf_wa),
    .wd  (rf_wd),
    .ra0 (op.a_adr),
    .ra1 (op.b_adr),
    .rd0 (rd_a),
    .rd1 (rd_b)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt   = state_r;
    in_pt.ready = 1'b0;
    unique case (state_r)
      tlls_pkg::S_IDLE: begin
        in_pt.ready = 1'b1;
        if (in_pt.valid) state_nxt = tlls_pkg::S_STORE;
      end
      tlls_pkg::S_STORE: begin
        if (st_k_r == 2'd2) begin
          state_nxt = (pts_r == 3'd5) ? tlls_pkg::S_FETCH : tlls_pkg::S_IDLE;
        end
      end
      tlls_pkg::S_FETCH: state_nxt = tlls_pkg::S_LOAD;
      tlls_pkg::S_LOAD:  state_nxt = tlls_pkg::S_MUL;
      tlls_pkg::S_MUL: begin
        if (cnt_r == '0) state_nxt = tlls_pkg::S_WB;
      end
      tlls_pkg::S_WB: begin
        if (op.act == tlls_pkg::ACT_DET && acc_zero) begin
          state_nxt = tlls_pkg::S_OUT;
        end else if (op.act == tlls_pkg::ACT_NEG && acc_neg) begin
          state_nxt = tlls_pkg::S_OUT;
        end else if (op.act == tlls_pkg::ACT_DIV) begin
          state_nxt = tlls_pkg::S_DIV;
        end else if (pc_r == PC_LAST) begin
          state_nxt = tlls_pkg::S_OUT;
        end else begin
          state_nxt = tlls_pkg::S_FETCH;
        end
      end
      tlls_pkg::S_DIV: begin
        if (dcnt_r == '0) begin
          state_nxt = (pc_r == PC_LAST) ? tlls_pkg::S_OUT : tlls_pkg::S_FETCH;
        end
      end
      tlls_pkg::S_OUT: begin
        if (out_free) state_nxt = tlls_pkg::S_IDLE;
      end
      default: state_nxt = tlls_pkg::S_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pts_r    <= '0;
      st_k_r   <= '0;
      pc_r     <= '0;
      status_r <= tlls_pkg::ST_OK;
      axis_r   <= '0;
    end else begin
      unique case (state_r)
        tlls_pkg::S_IDLE: begin
          st_k_r <= '0;
        end
        tlls_pkg::S_STORE: begin
          st_k_r <= st_k_r + 2'd1;
          if (st_k_r == 2'd2) begin
            pts_r    <= (pts_r == 3'd5) ? 3'd0 : pts_r + 3'd1;
            pc_r     <= '0;
            axis_r   <= '0;
            status_r <= tlls_pkg::ST_OK;
          end
        end
        tlls_pkg::S_WB: begin
          if (op.act == tlls_pkg::ACT_DET && acc_zero) begin
            status_r <= tlls_pkg::ST_SINGULAR;
          end else if (op.act == tlls_pkg::ACT_NEG && acc_neg) begin
            status_r <= tlls_pkg::ST_RANGE;
          end else if (op.act != tlls_pkg::ACT_DIV && pc_r != PC_LAST) begin
            pc_r <= pc_r + 1'b1;
          end
        end
        tlls_pkg::S_DIV: begin
          if (dcnt_r == '0) begin
            axis_r <= axis_r + 2'd1;
            if (pc_r != PC_LAST) pc_r <= pc_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // point capture and serial datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cu_r     <= coord_ext(in_pt.coord_u);
      cv_r     <= coord_ext(in_pt.coord_v);
      cw_r     <= coord_ext(in_pt.coord_w);
      st_adr_r <= tlls_pkg::RF_AW'({pts_r, 1'b0}) + tlls_pkg::RF_AW'(pts_r);
    end else if (state_r == tlls_pkg::S_STORE) begin
      st_adr_r <= st_adr_r + 1'b1;
    end
    case (state_r)
      tlls_pkg::S_LOAD: begin
        areg_r <= rd_a;
        cnt_r  <= op_len - 1'b1;
        if (op.clr) acc_r <= '0;
        case (op.bsrc)
          tlls_pkg::BSRC_REG: breg_r <= rd_b[BW-1:0];
          tlls_pkg::BSRC_IMM: breg_r <= {{(BW-4){op.imm[3]}}, op.imm};
          default:            breg_r <= det_neg_r ? '1 : BW'(1);
        endcase
      end
      tlls_pkg::S_MUL: begin
        if (breg_r[0]) begin
          if ((cnt_r == '0) ^ op.neg) acc_r <= acc_r - areg_r;
          else                        acc_r <= acc_r + areg_r;
        end
        areg_r <= areg_r << 1;
        breg_r <= breg_r >> 1;
        cnt_r  <= cnt_r - 1'b1;
      end
      tlls_pkg::S_WB: begin
        if (op.act == tlls_pkg::ACT_DET) det_neg_r <= acc_neg;
        if (op.act == tlls_pkg::ACT_D6)  d6_r <= acc_r;
        if (op.act == tlls_pkg::ACT_DIV) begin
          rem_r  <= acc_r + d6_sh;
          dvs_r  <= d6_sh;
          dcnt_r <= DVW'(COORD_WIDTH - 1);
          q_r    <= '0;
        end
      end
      tlls_pkg::S_DIV: begin
        if (div_ge) rem_r <= rem_r - dvs_r;
        dvs_r  <= dvs_r >> 1;
        q_r    <= q_fin;
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == '0) res_r[axis_r] <= 32'(q_res);
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == tlls_pkg::S_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tlls_pkg::S_OUT && out_free) begin
      out_status_r <= status_r;
      out_u_r      <= (status_r == tlls_pkg::ST_OK) ? res_r[0] : '0;
      out_v_r      <= (status_r == tlls_pkg::ST_OK) ? res_r[1] : '0;
      out_w_r      <= (status_r == tlls_pkg::ST_OK) ? res_r[2] : '0;
    end
  end

  assign out_res.valid    = out_valid_r;
  assign out_res.result_u = out_u_r;
  assign out_res.result_v = out_v_r;
  assign out_res.result_w = out_w_r;
  assign out_res.status   = out_status_r;

`ifndef SYNTHESIS
  // an error status always comes with a zero point
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.status != tlls_pkg::ST_OK) |->
      (out_res.result_u == '0 && out_res.result_v == '0 && out_res.result_w == '0))
    else $error("error status with nonzero point");

  // the sixth point of a set starts the solver
  a_sixth_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pts_r == 3'd5) |=> ##3 (state_r == tlls_pkg::S_FETCH))
    else $error("solver did not start after sixth point");

  // a new result word only leaves the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(state_r == tlls_pkg::S_OUT))
    else $error("result word raised outside output state");
`endif

endmodule

// File: tb/sv/three_line_least_squares_point_test.sv
// three_line_least_squares_point_test: sends six-point sets to the block and
// checks each averaged point and its status against an exact-integer predictor.
// Depends on tlls_pkg, tlls_if and three_line_least_squares_point.
`timescale 1ns / 1ps

module three_line_least_squares_point_test;

  typedef logic signed [511:0] big_t;

  typedef struct {
    logic [31:0]       u;
    logic [31:0]       v;
    logic [31:0]       w;
    tlls_pkg::status_t st;
  } meet_pt_t;

  localparam int KQ = 1 << 29;

  logic clk;
  logic rst_n;

  tlls_pt_if  in_if ();
  tlls_res_if out_if ();

  three_line_least_squares_point dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (in_if.sink),
    .out_res (out_if.source)
  );

  // predictor state: points of the current set and the expected meeting points
  logic signed [31:0] set_pts [6][3];
  int                 set_fill;
  meet_pt_t           meet_q [$];
  int                 err_cnt;
  int                 burst_left;
  bit                 hold_req;
  int                 hold_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor division, den > 0
  function automatic big_t floor_div(input big_t num, input big_t den);
    big_t q;
    q = num / den;
    if (num < 0 && q * den != num) q = q - 1;
    return q;
  endfunction

  // least-squares meeting point of lines AB, CD, EF, exact
  function automatic meet_pt_t solve_lines();
    big_t p [6][3];
    big_t d [3][3];
    big_t lm [9][3];
    big_t rv [9];
    big_t m [3][3];
    big_t rh [3];
    big_t n [3];
    big_t c00, c01, c02, c11, c12, c22, det, x;
    logic [31:0] r [3];
    meet_pt_t res;
    tlls_pkg::status_t st;
    st = tlls_pkg::ST_OK;
    for (int i = 0; i < 6; i++)
      for (int a = 0; a < 3; a++) p[i][a] = set_pts[i][a];
    for (int i = 0; i < 3; i++)
      for (int a = 0; a < 3; a++) d[i][a] = p[2*i+1][a] - p[2*i][a];
    for (int a = 0; a < 3; a++) begin
      lm[a][0] = d[0][a];    lm[a][1] = -d[1][a];  lm[a][2] = 0;
      lm[3+a][0] = 0;        lm[3+a][1] = d[1][a]; lm[3+a][2] = -d[2][a];
      lm[6+a][0] = -d[0][a]; lm[6+a][1] = 0;       lm[6+a][2] = d[2][a];
      rv[a]   = p[2][a] - p[0][a];
      rv[3+a] = p[4][a] - p[2][a];
      rv[6+a] = p[0][a] - p[4][a];
    end
    for (int i = 0; i < 3; i++) begin
      rh[i] = 0;
      for (int k = 0; k < 9; k++) rh[i] += rv[k] * lm[k][i];
      for (int j = 0; j < 3; j++) begin
        m[i][j] = 0;
        for (int k = 0; k < 9; k++) m[i][j] += lm[k][i] * lm[k][j];
      end
    end
    c00 = m[1][1]*m[2][2] - m[2][1]*m[2][1];
    c01 = m[2][0]*m[2][1] - m[1][0]*m[2][2];
    c02 = m[1][0]*m[2][1] - m[2][0]*m[1][1];
    c11 = m[0][0]*m[2][2] - m[2][0]*m[2][0];
    c12 = m[1][0]*m[2][0] - m[0][0]*m[2][1];
    c22 = m[0][0]*m[1][1] - m[1][0]*m[1][0];
    det = m[0][0]*c00 + m[1][0]*c01 + m[2][0]*c02;
    n[0] = rh[0]*c00 + rh[1]*c01 + rh[2]*c02;
    n[1] = rh[0]*c01 + rh[1]*c11 + rh[2]*c12;
    n[2] = rh[0]*c02 + rh[1]*c12 + rh[2]*c22;
    if (det == 0) begin
      st = tlls_pkg::ST_SINGULAR;
    end else begin
      if (det < 0) begin
        det = -det;
        for (int i = 0; i < 3; i++) n[i] = -n[i];
      end
      for (int i = 0; i < 3; i++)
        if (n[i] < 0 || n[i] > det) st = tlls_pkg::ST_RANGE;
    end
    for (int a = 0; a < 3; a++) begin
      r[a] = '0;
      if (st == tlls_pkg::ST_OK) begin
        x = (p[0][a] + p[2][a] + p[4][a]) * det;
        for (int i = 0; i < 3; i++) x += d[i][a] * n[i];
        x = floor_div(2*x + 3*det, 6*det);
        r[a] = x[31:0];
      end
    end
    res.u = r[0];
    res.v = r[1];
    res.w = r[2];
    res.st = st;
    return res;
  endfunction

  // sender: bursts of words with random gaps, prediction on acceptance
  task automatic send_point(input logic [31:0] cu, input logic [31:0] cv,
                            input logic [31:0] cw);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.coord_u <= cu;
    in_if.coord_v <= cv;
    in_if.coord_w <= cw;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    set_pts[set_fill][0] = cu;
    set_pts[set_fill][1] = cv;
    set_pts[set_fill][2] = cw;
    set_fill++;
    if (set_fill == 6) begin
      meet_q.push_back(solve_lines());
      set_fill = 0;
    end
  endtask

  task automatic send_line(input int au, av, aw, bu, bv, bw);
    send_point(au, av, aw);
    send_point(bu, bv, bw);
  endtask

  // well-formed set: three lines passing near a common point
  task automatic send_meeting_set();
    int cp [3];
    int dir [3];
    int sa, sb;
    for (int a = 0; a < 3; a++) cp[a] = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
    for (int i = 0; i < 3; i++) begin
      for (int a = 0; a < 3; a++)
        dir[a] = $signed($urandom_range(0, 1 << 27)) - (1 << 26);
      sa = $urandom_range(0, 3);
      sb = $urandom_range(0, 3);
      for (int h = 0; h < 2; h++)
        send_point(cp[0] + (h ? sb : -sa) * dir[0] + $signed($urandom_range(0, 2047)) - 1024,
                   cp[1] + (h ? sb : -sa) * dir[1] + $signed($urandom_range(0, 2047)) - 1024,
                   cp[2] + (h ? sb : -sa) * dir[2] + $signed($urandom_range(0, 2047)) - 1024);
    end
  endtask

  task automatic send_noise_set();
    for (int i = 0; i < 6; i++) send_point($urandom, $urandom, $urandom);
  endtask

  task automatic drain_wait();
    while (meet_q.size() != 0) @(posedge clk);
  endtask

  // receiver: stall pattern cycling through always, mostly and half ready, long hold on request
  always @(negedge clk) begin
    int phase;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      phase = 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 20000;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      phase++;
      case ((phase / 64) % 3)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    meet_pt_t exp_pt;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (meet_q.size() == 0) begin
        $error("unexpected result word u=%h v=%h w=%h status=%0d",
               out_if.result_u, out_if.result_v, out_if.result_w, out_if.status);
        err_cnt++;
      end else begin
        exp_pt = meet_q.pop_front();
        if (out_if.status !== exp_pt.st) begin
          $error("status expected %0d actual %0d", exp_pt.st, out_if.status);
          err_cnt++;
        end
        if (out_if.result_u !== exp_pt.u) begin
          $error("result_u expected %h actual %h", exp_pt.u, out_if.result_u);
          err_cnt++;
        end
        if (out_if.result_v !== exp_pt.v) begin
          $error("result_v expected %h actual %h", exp_pt.v, out_if.result_v);
          err_cnt++;
        end
        if (out_if.result_w !== exp_pt.w) begin
          $error("result_w expected %h actual %h", exp_pt.w, out_if.result_w);
          err_cnt++;
        end
      end
    end
  end

  // lines on the axes meeting at the origin, a singular set, a set meeting
  // beyond the first segment, and extreme coordinates
  task automatic test_directed();
    send_line(-KQ, 0, 0, KQ, 0, 0);
    send_line(0, -KQ, 0, 0, KQ, 0);
    send_line(0, 0, -KQ, 0, 0, KQ);
    for (int i = 0; i < 6; i++) send_point(0, 0, 0);
    send_line(0, 0, 0, KQ / 2, 0, 0);
    send_line(KQ, -KQ / 2, 0, KQ, KQ / 2, 0);
    send_line(KQ, 0, -KQ / 2, KQ, 0, KQ / 2);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_point(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
  endtask

  task automatic test_random_sets(input int n_sets);
    for (int s = 0; s < n_sets; s++) begin
      if ($urandom_range(0, 3) != 0) send_meeting_set();
      else send_noise_set();
    end
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int s = 0; s < 3; s++) send_meeting_set();
  endtask

  task automatic test_drain_pause();
    send_meeting_set();
    @(negedge clk);
    in_if.valid <= 1'b0;
    drain_wait();
    send_meeting_set();
  endtask

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.coord_u = '0;
    in_if.coord_v = '0;
    in_if.coord_w = '0;
    set_fill = 0;
    err_cnt = 0;
    burst_left = 0;
    hold_req = 1'b0;
    hold_left = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_sets(60);
    test_backpressure();
    test_drain_pause();
    test_random_sets(66);

    @(negedge clk);
    in_if.valid <= 1'b0;
    drain_wait();
    repeat (3000) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
